@@ hw/rtl/aoiet_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aoiet_pkg: shared types and constants for the event table unit
// Request and event codes, table entry layout and sequencer states.
// ----------------------------------------------------------------------------
package aoiet_pkg;

  localparam int unsigned MaxObjectsDefault = 64;

  typedef enum logic [1:0] {
    FUNC_ADD   = 2'd0,
    FUNC_MOVE  = 2'd1,
    FUNC_LEAVE = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    EV_ENTER = 2'd0,
    EV_MOVE  = 2'd1,
    EV_LEAVE = 2'd2,
    EV_NONE  = 2'd3
  } event_e;

  typedef struct packed {
    logic [1:0]         func;
    logic [15:0]        obj_id;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [14:0]        watch_radius;
  } req_t;

  typedef struct packed {
    logic [1:0]         event_kind;
    logic [15:0]        other_id;
    logic signed [15:0] other_x;
    logic signed [15:0] other_y;
    logic               last;
  } evt_t;

  typedef struct packed {
    logic [14:0]        radius;
    logic signed [15:0] y;
    logic signed [15:0] x;
    logic [15:0]        id;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND,
    ST_CLASS,
    ST_COMMIT,
    ST_SCAN,
    ST_EMIT
  } state_e;

  function automatic logic in_range(logic signed [15:0] cx, logic signed [15:0] cy,
                                    logic [14:0] r, logic signed [15:0] ox,
                                    logic signed [15:0] oy);
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic [16:0]        ax;
    logic [16:0]        ay;
    dx = 17'(ox) - 17'(cx);
    dy = 17'(oy) - 17'(cy);
    ax = dx[16] ? 17'(-dx) : 17'(dx);
    ay = dy[16] ? 17'(-dy) : 17'(dy);
    return (ax <= {2'b00, r}) && (ay <= {2'b00, r});
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/aoiet_stream_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aoiet_stream_if: valid/ready channel
// Carries one item of payload type T per handshake.
// ----------------------------------------------------------------------------
interface aoiet_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/area_of_interest_event_table_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// area_of_interest_event_table_unit: object table with range events
// Add, move and leave requests scan the table and emit enter, move and leave
// events for objects inside the requester's square watch area.
//
//   channel  dir  payload
//   req      in   func, obj_id, pos_x, pos_y, watch_radius
//   evt      out  event_kind, other_id, other_x, other_y, last
//
// After a request is taken: an id search pass, then a classification pass
// (which ends the request at once if it is ignored), then per event kind a
// minimum-id scan for each event plus a final empty one, then a commit step.
// One registered table read per cycle sets the pace.
// Reset clears all valid bits at once. A stalled event holds the sequencer.
// ----------------------------------------------------------------------------
module area_of_interest_event_table_unit
  import aoiet_pkg::*;
#(
  parameter int unsigned MAX_OBJECTS = MaxObjectsDefault
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  aoiet_stream_if.sink   req,
  aoiet_stream_if.source evt
);

  localparam int unsigned IW = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
  localparam int unsigned CW = $clog2(MAX_OBJECTS + 1);
  localparam logic [IW-1:0] LastIdx = IW'(MAX_OBJECTS - 1);

  entry_t                 mem_q  [MAX_OBJECTS];
  event_e                 kind_q [MAX_OBJECTS];
  logic [MAX_OBJECTS-1:0] vld_q;
  logic [CW-1:0]          count_q;

  state_e        state_q, state_d;
  req_t          req_q;
  logic [IW-1:0] idx_q;
  logic          iss_q;
  logic          pact_q;
  logic [IW-1:0] pidx_q;
  entry_t        rd_e_q;
  event_e        rd_k_q;
  logic          rd_v_q;
  logic [IW-1:0] self_q;
  logic          found_q;
  logic [IW-1:0] free_q;
  logic          free_ok_q;
  entry_t        me_q;
  event_e        pass_q;
  logic          prev_ok_q;
  logic [15:0]   prev_id_q;
  logic          best_ok_q;
  entry_t        best_e_q;
  evt_t          hold_q;
  logic          hold_v_q;
  evt_t          out_q;
  logic          out_vld_q;

  logic        scan_st;
  logic        pass_end;
  logic        out_free;
  logic        emit_go;
  logic        push_en;
  logic        out_vld_d;
  evt_t        push_data;
  logic [14:0] new_r;
  logic        new_in, old_in, hit;
  event_e      cls;
  logic        ok_go;

  assign scan_st  = (state_q == ST_FIND) || (state_q == ST_CLASS) || (state_q == ST_SCAN);
  assign pass_end = pact_q && (pidx_q == LastIdx);
  assign out_free = !out_vld_q || evt.ready;
  assign emit_go  = !hold_v_q || out_free;
  assign new_r    = (req_q.func == FUNC_ADD) ? req_q.watch_radius : me_q.radius;
  assign old_in   = in_range(me_q.x, me_q.y, me_q.radius, rd_e_q.x, rd_e_q.y);
  assign new_in   = in_range(req_q.pos_x, req_q.pos_y, new_r, rd_e_q.x, rd_e_q.y);
  assign hit      = pact_q && (rd_k_q == pass_q)
                    && (!prev_ok_q || rd_e_q.id > prev_id_q)
                    && (!best_ok_q || rd_e_q.id < best_e_q.id);

  always_comb begin
    cls = EV_NONE;
    if (rd_v_q && !(found_q && pidx_q == self_q)) begin
      case (req_q.func)
        FUNC_ADD: begin
          if (new_in) cls = EV_ENTER;
        end
        FUNC_MOVE: begin
          if (old_in && new_in) cls = EV_MOVE;
          else if (new_in) cls = EV_ENTER;
          else if (old_in) cls = EV_LEAVE;
        end
        FUNC_LEAVE: begin
          if (old_in) cls = EV_LEAVE;
        end
        default: cls = EV_NONE;
      endcase
    end
  end

  always_comb begin
    case (req_q.func) inside
      FUNC_ADD:   ok_go = !found_q && free_ok_q && (count_q < CW'(MAX_OBJECTS));
      FUNC_MOVE,
      FUNC_LEAVE: ok_go = found_q;
      default:    ok_go = 1'b0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (req.valid) state_d = ST_FIND;
      ST_FIND:   if (pass_end) state_d = ST_CLASS;
      ST_CLASS: begin
        if (!ok_go) state_d = ST_IDLE;
        else if (pass_end) state_d = ST_SCAN;
      end
      ST_SCAN:   if (pass_end) state_d = ST_EMIT;
      ST_EMIT: begin
        if (best_ok_q) begin
          if (emit_go) state_d = ST_SCAN;
        end else if (pass_q == EV_LEAVE) begin
          state_d = ST_COMMIT;
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_COMMIT: if (emit_go) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // the newest event waits in hold_q until the next one or the commit decides last
  always_comb begin
    push_en        = hold_v_q && out_free &&
                     (((state_q == ST_EMIT) && best_ok_q) || (state_q == ST_COMMIT));
    push_data      = hold_q;
    push_data.last = (state_q == ST_COMMIT);
    out_vld_d      = push_en || (out_vld_q && !evt.ready);
  end

  assign req.ready = (state_q == ST_IDLE);
  assign evt.valid = out_vld_q;
  assign evt.data  = out_q;

  always_ff @(posedge clk_i) begin
    rd_e_q <= mem_q[idx_q];
    rd_k_q <= kind_q[idx_q];
    rd_v_q <= vld_q[idx_q];
    pidx_q <= idx_q;
    if (state_q == ST_IDLE && req.valid) begin
      req_q <= req.data;
    end
    if (state_q == ST_FIND && pact_q && rd_v_q && rd_e_q.id == req_q.obj_id && !found_q) begin
      me_q <= rd_e_q;
    end
    if (state_q == ST_CLASS && pact_q) begin
      kind_q[pidx_q] <= cls;
    end
    if (state_q == ST_SCAN && hit) begin
      best_e_q <= rd_e_q;
    end
    if (state_q == ST_EMIT && best_ok_q && emit_go) begin
      hold_q    <= '{event_kind: pass_q, other_id: best_e_q.id,
                     other_x: best_e_q.x, other_y: best_e_q.y, last: 1'b0};
      prev_id_q <= best_e_q.id;
    end
    if (push_en) begin
      out_q <= push_data;
    end
    if (state_q == ST_COMMIT && emit_go) begin
      if (req_q.func == FUNC_ADD) begin
        mem_q[free_q] <= '{radius: req_q.watch_radius, y: req_q.pos_y,
                           x: req_q.pos_x, id: req_q.obj_id};
      end else if (req_q.func == FUNC_MOVE) begin
        mem_q[self_q] <= '{radius: me_q.radius, y: req_q.pos_y,
                           x: req_q.pos_x, id: req_q.obj_id};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      vld_q     <= '0;
      count_q   <= '0;
      idx_q     <= '0;
      iss_q     <= 1'b0;
      pact_q    <= 1'b0;
      self_q    <= '0;
      found_q   <= 1'b0;
      free_q    <= '0;
      free_ok_q <= 1'b0;
      pass_q    <= EV_ENTER;
      prev_ok_q <= 1'b0;
      best_ok_q <= 1'b0;
      hold_v_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      pact_q    <= scan_st && iss_q && (state_d == state_q);
      if (state_d != state_q) begin
        idx_q <= '0;
        iss_q <= 1'b1;
      end else if (scan_st && iss_q) begin
        idx_q <= idx_q + IW'(1);
        iss_q <= (idx_q != LastIdx);
      end
      unique case (state_q)
        ST_IDLE: begin
          found_q   <= 1'b0;
          free_ok_q <= 1'b0;
          pass_q    <= EV_ENTER;
          prev_ok_q <= 1'b0;
          best_ok_q <= 1'b0;
          hold_v_q  <= 1'b0;
        end
        ST_FIND: begin
          if (pact_q && rd_v_q && rd_e_q.id == req_q.obj_id && !found_q) begin
            found_q <= 1'b1;
            self_q  <= pidx_q;
          end
          if (pact_q && !rd_v_q && !free_ok_q) begin
            free_ok_q <= 1'b1;
            free_q    <= pidx_q;
          end
        end
        ST_CLASS: ;
        ST_SCAN: begin
          if (hit) best_ok_q <= 1'b1;
        end
        ST_EMIT: begin
          if (best_ok_q) begin
            if (emit_go) begin
              best_ok_q <= 1'b0;
              hold_v_q  <= 1'b1;
              prev_ok_q <= 1'b1;
            end
          end else if (pass_q != EV_LEAVE) begin
            if (pass_q == EV_ENTER) pass_q <= EV_MOVE;
            else pass_q <= EV_LEAVE;
            prev_ok_q <= 1'b0;
          end
        end
        ST_COMMIT: begin
          if (emit_go) begin
            hold_v_q <= 1'b0;
            if (req_q.func == FUNC_ADD) begin
              vld_q[free_q] <= 1'b1;
              count_q <= count_q + CW'(1);
            end else if (req_q.func == FUNC_LEAVE) begin
              vld_q[self_q] <= 1'b0;
              if (count_q != '0) count_q <= count_q - CW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  a_evt_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt.valid && !evt.ready |=> evt.valid && $stable(evt.data));
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_OBJECTS));
  a_count_vld: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(vld_q) == int'(count_q));
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !hold_v_q);
  a_pass_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pass_q != EV_NONE);

endmodule
`default_nettype wire
